// ===== rtl/jes_pkg.sv =====
package jes_pkg;

    localparam int DEF_MAX_SIZE = 8;
    localparam int TRIG_BITS    = 30;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEPS = 2'd2;

    localparam logic [3:0]  RST_SIZE   = 4'd8;
    localparam logic [30:0] RST_TOL    = 31'd66;
    localparam logic [7:0]  RST_SWEEPS = 8'd16;

    localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (TRIG_BITS - 1);
    localparam logic signed [33:0] SAT_MAX    = 34'sd2147483647;
    localparam logic signed [33:0] SAT_MIN    = -34'sd2147483648;

    // Request to the shared square-root / divide unit.
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [63:0] num;
        logic [31:0] den;
    } ser_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } ser_rsp_t;

    // Sum of two Q30 products, rounded half up and saturated to 32 bits.
    function automatic logic signed [31:0] rot_term(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [63:0] sum;
        logic signed [33:0] sh;
        sum = a + b + ROUND_HALF;
        sh  = 34'(sum >>> TRIG_BITS);
        if (sh > SAT_MAX)
        begin
            return 32'sh7fffffff;
        end
        if (sh < SAT_MIN)
        begin
            return 32'sh80000000;
        end
        return sh[31:0];
    endfunction

endpackage

// ===== rtl/jes_serial.sv =====
module jes_serial (
    input  logic               clk,
    input  logic               rst_n,
    input  jes_pkg::ser_req_t  req,
    output jes_pkg::ser_rsp_t  rsp
);
    import jes_pkg::*;

    logic        busy_reg, busy_next;
    logic        div_reg, div_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;

    logic [63:0] trial;
    logic [32:0] rem_shift;

    assign trial     = res_reg + bit_reg;
    assign rem_shift = {rem_reg, num_reg[63]};

    always_comb
    begin
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            cnt_next  = '0;
            num_next  = req.num;
            res_next  = '0;
            bit_next  = 64'd1 << 62;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                // Restoring division: one quotient bit per cycle.
                num_next = {num_reg[62:0], 1'b0};
                if (rem_shift >= {1'b0, den_reg})
                begin
                    rem_next    = 32'(rem_shift - {1'b0, den_reg});
                    num_next[0] = 1'b1;
                end
                else
                begin
                    rem_next = rem_shift[31:0];
                end
            end
            else
            begin
                if (num_reg >= trial)
                begin
                    num_next = num_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == (div_reg ? 6'd63 : 6'd31))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            div_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            div_reg  <= div_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = div_reg ? num_reg : res_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("serial unit started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("serial done without a run");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("serial done held");

endmodule

// ===== rtl/jacobi_eigen_sweep_unit.sv =====
// Loads n*n elements, one transaction per cycle; the last one starts the run.
// Each convergence check reads every element and compares the off-diagonal energy
// with tol squared; each nonzero pair computes its angle (normalize, two 32-step
// square roots and two 64-step divides in the shared serial unit), then rotates.
// Results leave one at a time; no input is taken from run start to last result.
// Reset (rst_n, asynchronous, active low) clears control and sets the config registers to defaults.
module jacobi_eigen_sweep_unit #(
    parameter int MAX_SIZE = jes_pkg::DEF_MAX_SIZE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,   // [31:0] element
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,   // [31:0] value
    output logic                          m_axis_tlast,
    output logic                          m_axis_tuser,   // [0] converged
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [jes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [30:0]                   cfg_data
);
    import jes_pkg::*;

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int SW    = $clog2(MAX_SIZE + 1);
    localparam int IW    = $clog2(MAX_SIZE);

    localparam logic [5:0] ST_IDLE    = 6'd0;
    localparam logic [5:0] ST_OD_RD   = 6'd1;
    localparam logic [5:0] ST_OD_SQ   = 6'd2;
    localparam logic [5:0] ST_OD_ACC  = 6'd3;
    localparam logic [5:0] ST_TOL_MUL = 6'd4;
    localparam logic [5:0] ST_TOL_CMP = 6'd5;
    localparam logic [5:0] ST_PQ_RD   = 6'd6;
    localparam logic [5:0] ST_PQ      = 6'd7;
    localparam logic [5:0] ST_PP      = 6'd8;
    localparam logic [5:0] ST_QQ      = 6'd9;
    localparam logic [5:0] ST_NORM_R  = 6'd10;
    localparam logic [5:0] ST_NORM_L  = 6'd11;
    localparam logic [5:0] ST_XX      = 6'd12;
    localparam logic [5:0] ST_YY      = 6'd13;
    localparam logic [5:0] ST_SQ1_GO  = 6'd14;
    localparam logic [5:0] ST_SQ1_WT  = 6'd15;
    localparam logic [5:0] ST_DD      = 6'd16;
    localparam logic [5:0] ST_DY      = 6'd17;
    localparam logic [5:0] ST_SQ2_GO  = 6'd18;
    localparam logic [5:0] ST_SQ2_WT  = 6'd19;
    localparam logic [5:0] ST_DIVC_GO = 6'd20;
    localparam logic [5:0] ST_DIVC_WT = 6'd21;
    localparam logic [5:0] ST_DIVS_GO = 6'd22;
    localparam logic [5:0] ST_DIVS_WT = 6'd23;
    localparam logic [5:0] ST_R_U     = 6'd24;
    localparam logic [5:0] ST_R_W     = 6'd25;
    localparam logic [5:0] ST_R_M1    = 6'd26;
    localparam logic [5:0] ST_R_M2    = 6'd27;
    localparam logic [5:0] ST_R_M3    = 6'd28;
    localparam logic [5:0] ST_R_M4    = 6'd29;
    localparam logic [5:0] ST_R_M5    = 6'd30;
    localparam logic [5:0] ST_E_RD    = 6'd31;
    localparam logic [5:0] ST_E_LD    = 6'd32;
    localparam logic [5:0] ST_E_HOLD  = 6'd33;

    function automatic logic [AW-1:0] at(input logic [IW-1:0] r, input logic [IW-1:0] c,
                                         input logic [SW-1:0] n);
        return AW'(int'(r) * int'(n) + int'(c));
    endfunction

    logic [31:0] mem [2**AW];
    logic signed [31:0] rd_data_reg;
    logic [AW-1:0] ra, wa;
    logic          we;
    logic [31:0]   wd;

    logic [5:0]  state_reg, state_next;
    logic [3:0]  size_reg, size_next;
    logic [30:0] tol_reg, tol_next;
    logic [7:0]  maxsw_reg, maxsw_next;
    logic [NW-1:0] load_reg, load_next;
    logic [NW-1:0] e_reg, e_next;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next;
    logic [IW-1:0] p_reg, p_next, q_reg, q_next, k_reg, k_next;
    logic        pass_reg, pass_next;
    logic [7:0]  done_reg, done_next;
    logic        conv_reg, conv_next;
    logic [63:0] sum_reg, sum_next;
    logic signed [63:0] tmp_reg, tmp_next;
    logic signed [31:0] apq_reg, apq_next, app_reg, app_next;
    logic signed [31:0] u_reg, u_next, w_reg, w_next;
    logic [32:0] x_reg, x_next, y_reg, y_next;
    logic        neg_reg, neg_next;
    logic [31:0] d_reg, d_next, h_reg, h_next;
    logic signed [32:0] c_reg, c_next, s_reg, s_next;
    logic        ov_reg, ov_next, ol_reg, ol_next;
    logic [31:0] od_reg, od_next;

    logic signed [32:0] ma, mb;
    logic signed [65:0] full_prod;
    logic signed [63:0] prod_reg;

    ser_req_t ser_req;
    ser_rsp_t ser_rsp;

    logic [SW-1:0] n_eff;
    logic [IW-1:0] n_last;
    logic [NW-1:0] nn;
    logic [AW-1:0] u_addr, w_addr;
    logic          adv_pair;
    logic signed [32:0] dx, dx_abs, apq_ext, apq_abs;
    logic [64:0]   sum_ext;

    jes_serial u_serial (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ser_req),
        .rsp   (ser_rsp)
    );

    always_comb
    begin
        if (size_reg < 4'd2)
        begin
            n_eff = SW'(2);
        end
        else if (int'(size_reg) > MAX_SIZE)
        begin
            n_eff = SW'(MAX_SIZE);
        end
        else
        begin
            n_eff = SW'(size_reg);
        end
    end

    assign n_last = IW'(int'(n_eff) - 1);
    assign nn     = NW'(int'(n_eff) * int'(n_eff));
    assign u_addr = pass_reg ? at(p_reg, k_reg, n_eff) : at(k_reg, p_reg, n_eff);
    assign w_addr = pass_reg ? at(q_reg, k_reg, n_eff) : at(k_reg, q_reg, n_eff);

    assign full_prod = ma * mb;
    assign sum_ext   = {1'b0, sum_reg} + {1'b0, prod_reg};
    assign apq_ext   = {apq_reg[31], apq_reg};
    assign apq_abs   = apq_ext[32] ? -apq_ext : apq_ext;
    assign dx        = {rd_data_reg[31], rd_data_reg} - {app_reg[31], app_reg};
    assign dx_abs    = dx[32] ? -dx : dx;

    always_comb
    begin
        unique case (state_reg)
            ST_OD_SQ:
            begin
                ma = {rd_data_reg[31], rd_data_reg};
                mb = {rd_data_reg[31], rd_data_reg};
            end
            ST_TOL_MUL:
            begin
                ma = {2'b00, tol_reg};
                mb = {2'b00, tol_reg};
            end
            ST_XX:
            begin
                ma = x_reg;
                mb = x_reg;
            end
            ST_YY, ST_DY:
            begin
                ma = y_reg;
                mb = y_reg;
            end
            ST_DD:
            begin
                ma = {1'b0, d_reg};
                mb = {1'b0, d_reg};
            end
            ST_R_M1:
            begin
                ma = {u_reg[31], u_reg};
                mb = c_reg;
            end
            ST_R_M2:
            begin
                ma = {w_reg[31], w_reg};
                mb = -s_reg;
            end
            ST_R_M3:
            begin
                ma = {u_reg[31], u_reg};
                mb = s_reg;
            end
            ST_R_M4:
            begin
                ma = {w_reg[31], w_reg};
                mb = c_reg;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        tol_next   = tol_reg;
        maxsw_next = maxsw_reg;
        load_next  = load_reg;
        e_next     = e_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        k_next     = k_reg;
        pass_next  = pass_reg;
        done_next  = done_reg;
        conv_next  = conv_reg;
        sum_next   = sum_reg;
        tmp_next   = tmp_reg;
        apq_next   = apq_reg;
        app_next   = app_reg;
        u_next     = u_reg;
        w_next     = w_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        neg_next   = neg_reg;
        d_next     = d_reg;
        h_next     = h_reg;
        c_next     = c_reg;
        s_next     = s_reg;
        ov_next    = ov_reg;
        ol_next    = ol_reg;
        od_next    = od_reg;
        ra         = '0;
        wa         = '0;
        we         = 1'b0;
        wd         = '0;
        ser_req    = '0;
        adv_pair   = 1'b0;

        if (cfg_valid)
        begin
            priority case (cfg_index)
                REG_SIZE:   size_next  = cfg_data[3:0];
                REG_TOL:    tol_next   = cfg_data;
                REG_SWEEPS: maxsw_next = cfg_data[7:0];
                default:    ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    we = 1'b1;
                    wa = load_reg[AW-1:0];
                    wd = s_axis_tdata;
                    if ((NW+1)'(load_reg) + (NW+1)'(1) >= (NW+1)'(nn))
                    begin
                        load_next  = '0;
                        i_next     = '0;
                        j_next     = '0;
                        sum_next   = '0;
                        done_next  = '0;
                        state_next = ST_OD_RD;
                    end
                    else
                    begin
                        load_next = load_reg + NW'(1);
                    end
                end
            end
            ST_OD_RD:
            begin
                ra         = at(i_reg, j_reg, n_eff);
                state_next = ST_OD_SQ;
            end
            ST_OD_SQ:
            begin
                state_next = ST_OD_ACC;
            end
            ST_OD_ACC:
            begin
                if (i_reg != j_reg)
                begin
                    sum_next = sum_ext[64] ? '1 : sum_ext[63:0];
                end
                state_next = ST_OD_RD;
                if (j_reg == n_last)
                begin
                    j_next = '0;
                    if (i_reg == n_last)
                    begin
                        state_next = ST_TOL_MUL;
                    end
                    else
                    begin
                        i_next = i_reg + IW'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                end
            end
            ST_TOL_MUL:
            begin
                state_next = ST_TOL_CMP;
            end
            ST_TOL_CMP:
            begin
                if (sum_reg <= $unsigned(prod_reg))
                begin
                    conv_next  = 1'b1;
                    e_next     = '0;
                    state_next = ST_E_RD;
                end
                else if (done_reg >= maxsw_reg)
                begin
                    conv_next  = 1'b0;
                    e_next     = '0;
                    state_next = ST_E_RD;
                end
                else
                begin
                    p_next     = '0;
                    q_next     = IW'(1);
                    state_next = ST_PQ_RD;
                end
            end
            ST_PQ_RD:
            begin
                ra         = at(p_reg, q_reg, n_eff);
                state_next = ST_PQ;
            end
            ST_PQ:
            begin
                if (rd_data_reg == 32'sd0)
                begin
                    adv_pair = 1'b1;
                end
                else
                begin
                    apq_next   = rd_data_reg;
                    ra         = at(p_reg, p_reg, n_eff);
                    state_next = ST_PP;
                end
            end
            ST_PP:
            begin
                app_next   = rd_data_reg;
                ra         = at(q_reg, q_reg, n_eff);
                state_next = ST_QQ;
            end
            ST_QQ:
            begin
                x_next     = dx_abs;
                y_next     = {apq_abs[31:0], 1'b0};
                neg_next   = apq_reg[31] ^ dx[32];
                state_next = ST_NORM_R;
            end
            ST_NORM_R:
            begin
                if ((x_reg[32:30] != 3'd0) || (y_reg[32:30] != 3'd0))
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                end
                else
                begin
                    state_next = ST_NORM_L;
                end
            end
            ST_NORM_L:
            begin
                if ((x_reg[32:29] == 4'd0) && (y_reg[32:29] == 4'd0))
                begin
                    x_next = x_reg << 1;
                    y_next = y_reg << 1;
                end
                else
                begin
                    state_next = ST_XX;
                end
            end
            ST_XX:
            begin
                state_next = ST_YY;
            end
            ST_YY:
            begin
                tmp_next   = prod_reg;
                state_next = ST_SQ1_GO;
            end
            ST_SQ1_GO:
            begin
                ser_req.start = 1'b1;
                ser_req.num   = 64'(tmp_reg + prod_reg);
                state_next    = ST_SQ1_WT;
            end
            ST_SQ1_WT:
            begin
                if (ser_rsp.done)
                begin
                    d_next     = x_reg[31:0] + ser_rsp.result[31:0];
                    state_next = ST_DD;
                end
            end
            ST_DD:
            begin
                state_next = ST_DY;
            end
            ST_DY:
            begin
                tmp_next   = prod_reg;
                state_next = ST_SQ2_GO;
            end
            ST_SQ2_GO:
            begin
                ser_req.start = 1'b1;
                ser_req.num   = 64'(tmp_reg + prod_reg);
                state_next    = ST_SQ2_WT;
            end
            ST_SQ2_WT:
            begin
                if (ser_rsp.done)
                begin
                    h_next     = ser_rsp.result[31:0];
                    state_next = ST_DIVC_GO;
                end
            end
            ST_DIVC_GO:
            begin
                ser_req.start  = 1'b1;
                ser_req.is_div = 1'b1;
                ser_req.num    = (64'(d_reg) << TRIG_BITS) + 64'(h_reg >> 1);
                ser_req.den    = h_reg;
                state_next     = ST_DIVC_WT;
            end
            ST_DIVC_WT:
            begin
                if (ser_rsp.done)
                begin
                    c_next     = ser_rsp.result[32:0];
                    state_next = ST_DIVS_GO;
                end
            end
            ST_DIVS_GO:
            begin
                ser_req.start  = 1'b1;
                ser_req.is_div = 1'b1;
                ser_req.num    = (64'(y_reg) << TRIG_BITS) + 64'(h_reg >> 1);
                ser_req.den    = h_reg;
                state_next     = ST_DIVS_WT;
            end
            ST_DIVS_WT:
            begin
                if (ser_rsp.done)
                begin
                    s_next     = neg_reg ? -$signed(ser_rsp.result[32:0])
                                         : $signed(ser_rsp.result[32:0]);
                    pass_next  = 1'b0;
                    k_next     = '0;
                    state_next = ST_R_U;
                end
            end
            ST_R_U:
            begin
                ra         = u_addr;
                state_next = ST_R_W;
            end
            ST_R_W:
            begin
                u_next     = rd_data_reg;
                ra         = w_addr;
                state_next = ST_R_M1;
            end
            ST_R_M1:
            begin
                w_next     = rd_data_reg;
                state_next = ST_R_M2;
            end
            ST_R_M2:
            begin
                tmp_next   = prod_reg;
                state_next = ST_R_M3;
            end
            ST_R_M3:
            begin
                we         = 1'b1;
                wa         = u_addr;
                wd         = rot_term(tmp_reg, prod_reg);
                state_next = ST_R_M4;
            end
            ST_R_M4:
            begin
                tmp_next   = prod_reg;
                state_next = ST_R_M5;
            end
            ST_R_M5:
            begin
                we         = 1'b1;
                wa         = w_addr;
                wd         = rot_term(tmp_reg, prod_reg);
                state_next = ST_R_U;
                if (k_reg == n_last)
                begin
                    k_next = '0;
                    if (pass_reg)
                    begin
                        adv_pair = 1'b1;
                    end
                    else
                    begin
                        pass_next = 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end
            ST_E_RD:
            begin
                ra         = e_reg[AW-1:0];
                state_next = ST_E_LD;
            end
            ST_E_LD:
            begin
                od_next    = rd_data_reg;
                ol_next    = (e_reg == nn - NW'(1));
                ov_next    = 1'b1;
                state_next = ST_E_HOLD;
            end
            ST_E_HOLD:
            begin
                if (m_axis_tready)
                begin
                    ov_next = 1'b0;
                    if (ol_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        e_next     = e_reg + NW'(1);
                        state_next = ST_E_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Step to the next pair of the cyclic order, or close the sweep.
        if (adv_pair)
        begin
            state_next = ST_PQ_RD;
            if (q_reg == n_last)
            begin
                if (int'(p_reg) + 2 == int'(n_eff))
                begin
                    done_next  = done_reg + 8'd1;
                    i_next     = '0;
                    j_next     = '0;
                    sum_next   = '0;
                    state_next = ST_OD_RD;
                end
                else
                begin
                    p_next = p_reg + IW'(1);
                    q_next = IW'(int'(p_reg) + 2);
                end
            end
            else
            begin
                q_next = q_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[ra];
        prod_reg    <= full_prod[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            size_reg  <= RST_SIZE;
            tol_reg   <= RST_TOL;
            maxsw_reg <= RST_SWEEPS;
            load_reg  <= '0;
            e_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            p_reg     <= '0;
            q_reg     <= '0;
            k_reg     <= '0;
            pass_reg  <= 1'b0;
            done_reg  <= '0;
            conv_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            ol_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            tol_reg   <= tol_next;
            maxsw_reg <= maxsw_next;
            load_reg  <= load_next;
            e_reg     <= e_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            p_reg     <= p_next;
            q_reg     <= q_next;
            k_reg     <= k_next;
            pass_reg  <= pass_next;
            done_reg  <= done_next;
            conv_reg  <= conv_next;
            ov_reg    <= ov_next;
            ol_reg    <= ol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        tmp_reg <= tmp_next;
        apq_reg <= apq_next;
        app_reg <= app_next;
        u_reg   <= u_next;
        w_reg   <= w_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        neg_reg <= neg_next;
        d_reg   <= d_next;
        h_reg   <= h_next;
        c_reg   <= c_next;
        s_reg   <= s_next;
        od_reg  <= od_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;
    assign m_axis_tuser  = conv_reg;
    assign cfg_ready     = 1'b1;

    a_out_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (state_reg == ST_E_HOLD))
        else $error("result valid outside the emit hold state");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while results pending");
    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (state_next == ST_OD_RD)) |=> !s_axis_tready)
        else $error("block still ready after the last element");
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        (we && (state_reg != ST_IDLE)) |-> ((state_reg == ST_R_M3) || (state_reg == ST_R_M5)))
        else $error("unexpected matrix store write");

endmodule

// ===== verif/jacobi_eigen_sweep_unit_tb.sv =====
`timescale 1ns / 100ps

module jacobi_eigen_sweep_unit_tb;

    import jes_pkg::*;

    localparam int  CLK_HALF    = 10;
    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  HOLD_CYCLES = 600;
    localparam int  SETTLE      = 40;

    typedef struct {
        logic [31:0] value;
        bit          last;
        bit          conv;
    } entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [30:0] cfg_data = '0;

    // Shadow of the block: registers, element store and load position.
    logic [3:0]  sh_size   = RST_SIZE;
    logic [30:0] sh_tol    = RST_TOL;
    logic [7:0]  sh_sweeps = RST_SWEEPS;
    longint      elem_store [64];
    int          load_pos = 0;

    logic [31:0] element_q [$];
    entry_t      eigen_q [$];
    int          sent_cnt = 0;
    int          taken_cnt = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_go = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int          err_cnt = 0;
    int          cycle_cnt = 0;

    jacobi_eigen_sweep_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] element
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] value
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),   // [0] converged
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic longint unsigned isqrt_u64(input longint unsigned num);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > num)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (num >= res + b)
            begin
                num = num - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Two Q30 products summed, rounded half up, saturated to 32 bits.
    function automatic longint rot_round(input longint u, input longint k1,
                                         input longint w, input longint k2);
        longint acc;
        acc = u * k1 + w * k2 + (64'sd1 <<< 29);
        acc = acc >>> 30;
        if (acc > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (acc < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return acc;
    endfunction

    function automatic void rotation_coeffs(input longint app, input longint aqq,
                                            input longint apq,
                                            output longint c, output longint s);
        longint dx;
        bit neg;
        longint unsigned x, y, r, d, h;
        dx = aqq - app;
        neg = apq < 0;
        if (dx < 0)
        begin
            dx = -dx;
            neg = !neg;
        end
        x = dx;
        y = (apq < 0 ? -apq : apq) * 2;
        while (x >= (64'd1 << 30) || y >= (64'd1 << 30))
        begin
            x = x >> 1;
            y = y >> 1;
        end
        while (x < (64'd1 << 29) && y < (64'd1 << 29))
        begin
            x = x << 1;
            y = y << 1;
        end
        r = isqrt_u64(x * x + y * y);
        d = x + r;
        h = isqrt_u64(d * d + y * y);
        c = ((d << 30) + h / 2) / h;
        s = ((y << 30) + h / 2) / h;
        if (neg)
        begin
            s = -s;
        end
    endfunction

    function automatic longint unsigned offdiag_energy(input int n);
        longint unsigned acc, m, sq;
        longint v;
        acc = 0;
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
            begin
                if (i != j)
                begin
                    v = elem_store[i * n + j];
                    m = v < 0 ? -v : v;
                    sq = m * m;
                    acc = (acc > 64'hffff_ffff_ffff_ffff - sq) ? 64'hffff_ffff_ffff_ffff
                                                             : acc + sq;
                end
            end
        end
        return acc;
    endfunction

    function automatic void jacobi_sweep(input int n);
        longint c, s, u, w;
        for (int p = 0; p + 1 < n; p++)
        begin
            for (int q = p + 1; q < n; q++)
            begin
                if (elem_store[p * n + q] != 0)
                begin
                    rotation_coeffs(elem_store[p * n + p], elem_store[q * n + q],
                                    elem_store[p * n + q], c, s);
                    for (int k = 0; k < n; k++)
                    begin
                        u = elem_store[k * n + p];
                        w = elem_store[k * n + q];
                        elem_store[k * n + p] = rot_round(u, c, w, -s);
                        elem_store[k * n + q] = rot_round(u, s, w, c);
                    end
                    for (int k = 0; k < n; k++)
                    begin
                        u = elem_store[p * n + k];
                        w = elem_store[q * n + k];
                        elem_store[p * n + k] = rot_round(u, c, w, -s);
                        elem_store[q * n + k] = rot_round(u, s, w, c);
                    end
                end
            end
        end
    endfunction

    // Stores one element; the element that completes the matrix runs the sweeps
    // and queues the whole rotated matrix.
    function automatic void load_element(input logic [31:0] elem);
        int n, done;
        bit conv;
        longint unsigned tol2;
        entry_t e;
        n = (sh_size < 2) ? 2 : (sh_size > 8) ? 8 : int'(sh_size);
        elem_store[load_pos & 63] = longint'($signed(elem));
        load_pos++;
        if (load_pos < n * n)
        begin
            return;
        end
        tol2 = longint'(sh_tol) * longint'(sh_tol);
        done = 0;
        conv = 1'b0;
        forever
        begin
            if (offdiag_energy(n) <= tol2)
            begin
                conv = 1'b1;
                break;
            end
            if (done >= sh_sweeps)
            begin
                break;
            end
            jacobi_sweep(n);
            done++;
        end
        for (int k = 0; k < n * n; k++)
        begin
            e.value = elem_store[k][31:0];
            e.last = (k + 1 == n * n);
            e.conv = conv;
            eigen_q.push_back(e);
        end
        load_pos = 0;
    endfunction

    // Driver for the element stream.
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || taken_cnt == sent_cnt)
        begin
            if (element_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tdata <= element_q.pop_front();
                s_axis_tvalid <= 1'b1;
                sent_cnt <= sent_cnt + 1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver; the long hold-off is counted here and starts once results wait.
    always @(negedge clk)
    begin
        if (hold_go && !hold_done && hold_left == 0 && m_axis_tvalid)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predicts on each accepted element and checks each result.
    always @(posedge clk)
    begin
        entry_t exp_e;
        cycle_cnt <= cycle_cnt + 1;
        if (s_axis_tvalid && s_axis_tready)
        begin
            load_element(s_axis_tdata);
            taken_cnt <= taken_cnt + 1;
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (eigen_q.size() == 0)
            begin
                err_cnt = err_cnt + 1;
                if (err_cnt <= 10)
                begin
                    $display("unexpected result value=%h last=%b conv=%b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
            end
            else
            begin
                exp_e = eigen_q.pop_front();
                if (m_axis_tdata !== exp_e.value || m_axis_tlast !== exp_e.last
                    || m_axis_tuser !== exp_e.conv)
                begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= 10)
                    begin
                        $display("mismatch: expected value=%h last=%b conv=%b, got %h %b %b",
                                 exp_e.value, exp_e.last, exp_e.conv,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            REG_SIZE:   sh_size = val[3:0];
            REG_TOL:    sh_tol = val;
            REG_SWEEPS: sh_sweeps = val[7:0];
            default:    ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (element_q.size() != 0 || taken_cnt != sent_cnt || eigen_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_element();
        if ($urandom_range(2) == 0)
        begin
            return $urandom;
        end
        return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
    endfunction

    // About one in five is unsymmetric; zeroed entries can break the rest too.
    task automatic push_matrices(input int n, input int count);
        logic [31:0] m [8][8];
        bit sym;
        for (int t = 0; t < count; t++)
        begin
            sym = $urandom_range(4) != 0;
            for (int i = 0; i < n; i++)
            begin
                for (int j = 0; j < n; j++)
                begin
                    m[i][j] = (sym && j < i) ? m[j][i] : rand_element();
                    if ($urandom_range(7) == 0)
                    begin
                        m[i][j] = '0;
                    end
                end
            end
            for (int i = 0; i < n; i++)
            begin
                for (int j = 0; j < n; j++)
                begin
                    element_q.push_back(m[i][j]);
                end
            end
        end
    endtask

    task automatic run_phase(input logic [3:0] sz, input logic [30:0] tol,
                             input logic [7:0] sw, input int count,
                             input int s_pct, input int r_pct);
        int n;
        reg_write(REG_SIZE, 31'(sz));
        reg_write(REG_TOL, tol);
        reg_write(REG_SWEEPS, 31'(sw));
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        n = (sz < 2) ? 2 : (sz > 8) ? 8 : int'(sz);
        push_matrices(n, count);
        wait_drained();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero off-diagonal, equal diagonals of both signs,
        // an unsymmetric matrix and full-scale extremes.
        reg_write(REG_SIZE, 31'd2);
        reg_write(REG_TOL, 31'd66);
        reg_write(REG_SWEEPS, 31'd16);
        element_q = '{32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000,
                      32'h0003_0000, 32'h0001_8000, 32'h0001_8000, 32'h0003_0000,
                      32'h0003_0000, 32'hfffe_8000, 32'hfffe_8000, 32'h0003_0000,
                      32'h0001_0000, 32'h0003_0000, 32'hfffe_0000, 32'h0005_0000,
                      32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                      32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
        wait_drained();

        // Size above range saturates to the largest matrix.
        run_phase(4'd15, 31'd66, 8'd16, 1, 53, 0);

        // Zero tolerance with the largest sweep limit, under a long receiver hold.
        hold_go = 1'b1;
        run_phase(4'd2, 31'd0, 8'd255, 3, 0, 53);

        run_phase(4'd3, 31'h7fff_ffff, 8'd1, 4, 28, 28);

        // Size below range and no sweeps at all.
        run_phase(4'd0, 31'd1000, 8'd0, 3, 0, 0);
        run_phase(4'd1, 31'd66, 8'd4, 2, 0, 0);

        run_phase(4'd4, 31'd66, 8'd16, 1, 53, 0);

        // Shrinking the size partway through a load starts the run early.
        reg_write(REG_SIZE, 31'd3);
        element_q = '{rand_element(), rand_element()};
        wait_drained();
        reg_write(REG_SIZE, 31'd2);
        element_q = '{rand_element(), rand_element()};
        wait_drained();

        run_phase(4'd3, 31'd500, 8'd8, 2, 28, 28);

        repeat (200) @(posedge clk);
        if (err_cnt == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
